/* sv/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types, constants and cipher functions of the feistel ctr cipher unit
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned QDepth = 2;

  localparam logic [WordW-1:0] LcgMul = 32'd340660715;
  localparam logic [WordW-1:0] LcgAdd = 32'd535838461;
  localparam logic [HalfW-1:0] KeyMix = 16'h7C36;

  localparam logic [3:0] SfcSbox [16] = '{
    4'd5, 4'd13, 4'd2, 4'd8, 4'd10, 4'd12, 4'd11, 4'd15,
    4'd0, 4'd7, 4'd14, 4'd6, 4'd9, 4'd1, 4'd3, 4'd4
  };

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_MASTER_KEY     = 1'b0,
    REG_INITIAL_VECTOR = 1'b1
  } sfc_reg_t;

  // one queued item: data block and its advanced counter value
  typedef struct packed {
    logic [WordW-1:0] pt;
    logic [WordW-1:0] ctr;
  } sfc_item_t;

  // queue status seen by the front part
  typedef struct packed {
    logic full;
    logic empty;
  } sfc_qstat_t;

  function automatic logic [HalfW-1:0] sfc_sp16(input logic [HalfW-1:0] x,
                                                input logic [HalfW-1:0] k);
    logic [HalfW-1:0] t;
    logic [HalfW-1:0] sub;
    logic [HalfW-1:0] res;
    t   = x ^ k;
    sub = '0;
    res = '0;
    for (int n = 0; n < HalfW / 4; n++) begin
      sub[4*n +: 4] = SfcSbox[t[4*n +: 4]];
    end
    for (int i = 0; i < HalfW; i++) begin
      res[(31 * i + 5) % HalfW] = sub[i];
    end
    return res;
  endfunction

  function automatic logic [WordW-1:0] sfc_sp32(input logic [WordW-1:0] x,
                                                input logic [WordW-1:0] k);
    logic [WordW-1:0] t;
    logic [WordW-1:0] sub;
    logic [WordW-1:0] res;
    t   = x ^ k;
    sub = '0;
    res = '0;
    for (int n = 0; n < WordW / 4; n++) begin
      sub[4*n +: 4] = SfcSbox[t[4*n +: 4]];
    end
    for (int i = 0; i < WordW; i++) begin
      res[(31 * i + 5) % WordW] = sub[i];
    end
    return res;
  endfunction

  // lai-massey round, 32-bit sp layer and half swap
  function automatic logic [WordW-1:0] sfc_mix(input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] key);
    logic [HalfW-1:0] k1;
    logic [HalfW-1:0] k2;
    logic [HalfW-1:0] s;
    logic [WordW-1:0] m;
    logic [WordW-1:0] key32;
    logic [WordW-1:0] p;
    k1    = key[31:16];
    k2    = key[15:0];
    s     = sfc_sp16(c[31:16] ^ c[15:0], {k2[1:0], k2[15:2]});
    m     = {c[31:16] ^ s, c[15:0] ^ s};
    key32 = {{k1[6:0], k1[15:7]} ^ k2 ^ KeyMix, {k2[12:0], k2[15:13]}};
    p     = sfc_sp32(m, key32);
    return {p[15:0], p[31:16]};
  endfunction

  // two feistel rounds, keyed k1 then k2
  function automatic logic [WordW-1:0] sfc_rounds(input logic [WordW-1:0] c,
                                                  input logic [WordW-1:0] key);
    logic [WordW-1:0] r1;
    r1 = {c[15:0], c[31:16] ^ sfc_sp16(c[15:0], key[31:16])};
    return {r1[15:0], r1[31:16] ^ sfc_sp16(r1[15:0], key[15:0])};
  endfunction

endpackage

/* sv/sfc_front.sv */
// ----------------------------------------------------------------------------
// sfc_front
// configuration registers, keystream counter and item intake
// ----------------------------------------------------------------------------
module sfc_front
  import sfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [0:0]       cfg_index,
  input  logic [WordW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WordW-1:0] in_block,
  input  logic             in_last,
  input  sfc_qstat_t       qstat,
  output logic             push,
  output sfc_item_t        push_item,
  output logic [WordW-1:0] master_key
);

  logic [WordW-1:0] initial_vector;
  logic [WordW-1:0] counter;
  logic [WordW-1:0] counter_adv;

  // one lcg step, low word only
  assign counter_adv = counter * LcgMul + LcgAdd;

  assign in_ready       = !qstat.full;
  assign push           = in_valid && in_ready;
  assign push_item.pt   = in_block;
  assign push_item.ctr  = counter_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_key     <= '0;
      initial_vector <= '0;
      counter        <= '0;
    end else begin
      if (push) begin
        counter <= in_last ? initial_vector : counter_adv;
      end
      if (cfg_valid) begin
        unique case (sfc_reg_t'(cfg_index))
          REG_MASTER_KEY: begin
            master_key <= cfg_data;
          end
          REG_INITIAL_VECTOR: begin
            initial_vector <= cfg_data;
            counter        <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* sv/sfc_queue.sv */
// ----------------------------------------------------------------------------
// sfc_queue
// two-entry queue between intake and cipher pipeline
// ----------------------------------------------------------------------------
module sfc_queue
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sfc_item_t  push_item,
  input  logic       pop,
  output sfc_item_t  head,
  output sfc_qstat_t qstat
);

  sfc_item_t  entries [QDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == 2'(QDepth));
  assign qstat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QDepth)) else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push) else $error("push into full queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count did not follow push");

endmodule

/* sv/sfc_back.sv */
// ----------------------------------------------------------------------------
// sfc_back
// two-stage cipher pipeline with registered result
// ----------------------------------------------------------------------------
module sfc_back
  import sfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [WordW-1:0] master_key,
  input  sfc_qstat_t       qstat,
  input  sfc_item_t        head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_block
);

  logic             mix_valid;
  logic [WordW-1:0] mix_pt;
  logic [WordW-1:0] mix_state;
  logic             take;

  // result register frees when empty or being taken
  assign take = mix_valid && (!out_valid || out_ready);
  assign pop  = !qstat.empty && (!mix_valid || take);

  always_ff @(posedge clk) begin
    if (pop) begin
      mix_pt    <= head.pt;
      mix_state <= sfc_mix(head.ctr, master_key);
    end
    if (take) begin
      out_block <= mix_pt ^ sfc_rounds(mix_state, master_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mix_valid <= 1'b1;
      end else if (take) begin
        mix_valid <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid) else $error("result lost after stage move");
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (mix_valid && out_valid && !out_ready) |=> mix_valid)
    else $error("mix stage dropped while stalled");
  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!mix_valid || take)) else $error("pop into occupied stage");

endmodule

/* sv/sp_feistel_ctr_cipher32_unit.sv */
// ----------------------------------------------------------------------------
// sp_feistel_ctr_cipher32_unit
// counter-mode stream cipher on 32-bit items with a toy sp/feistel cipher
// ----------------------------------------------------------------------------
// path: an accepted item goes through a queue entry, the mix stage and the result register
// throughput: one item per cycle while the receiver does not stall, set by the single lcg step of the counter
// the cipher runs in two pipeline stages behind a two-entry queue
// reset: key, initial vector and counter clear to zero, queue and stages empty
// configuration writes are always taken
// ----------------------------------------------------------------------------
module sp_feistel_ctr_cipher32_unit
  import sfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,   // 0 master_key, 1 initial_vector
  input  logic [WordW-1:0] cfg_data,
  // input items
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [WordW-1:0] s_axis_tdata,  // [31:0] plaintext_block
  input  logic             s_axis_tlast,  // last_block
  // result items
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [WordW-1:0] m_axis_tdata   // [31:0] cipher_block
);

  logic             push;
  logic             pop;
  sfc_item_t        push_item;
  sfc_item_t        head;
  sfc_qstat_t       qstat;
  logic [WordW-1:0] master_key;

  // configuration never stalls
  assign cfg_ready = 1'b1;

  // front: registers, counter advance per item, reload after a last item
  sfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_block   (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item),
    .master_key (master_key)
  );

  // queue decouples intake from the cipher pipeline
  sfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: enciphers the counter and xors the data block
  sfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .master_key (master_key),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_block  (m_axis_tdata)
  );

endmodule

/* bench/sfc_stream_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfc_stream_checker
// watches the register, input and result channels of the feistel ctr cipher
// unit, predicts every cipher block and compares it with what comes out
// ----------------------------------------------------------------------------
module sfc_stream_checker
  import sfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [WordW-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [WordW-1:0] s_axis_tdata,   // [31:0] plaintext_block
  input  logic             s_axis_tlast,   // last_block
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [WordW-1:0] m_axis_tdata,   // [31:0] cipher_block
  output int unsigned      mismatches,
  output int unsigned      outstanding
);

  logic [31:0] key_shadow;
  logic [31:0] iv_shadow;
  logic [31:0] ctr_shadow;
  logic [31:0] cipher_due[$];
  int unsigned results_seen;

  function automatic logic [3:0] nibble_sub(input logic [3:0] n);
    case (n)
      4'd0:  return 4'd5;
      4'd1:  return 4'd13;
      4'd2:  return 4'd2;
      4'd3:  return 4'd8;
      4'd4:  return 4'd10;
      4'd5:  return 4'd12;
      4'd6:  return 4'd11;
      4'd7:  return 4'd15;
      4'd8:  return 4'd0;
      4'd9:  return 4'd7;
      4'd10: return 4'd14;
      4'd11: return 4'd6;
      4'd12: return 4'd9;
      4'd13: return 4'd1;
      4'd14: return 4'd3;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic [15:0] rot16(input logic [15:0] v, input int unsigned n);
    return (v << n) | (v >> (16 - n));
  endfunction

  // key xor, nibble substitution, bit i moved to (31i+5) mod width
  function automatic logic [31:0] subst_perm(input logic [31:0] x, input logic [31:0] k,
                                             input int unsigned width);
    logic [31:0] t;
    logic [31:0] sub;
    logic [31:0] res;
    t   = x ^ k;
    sub = '0;
    res = '0;
    for (int unsigned i = 0; i < width; i += 4) sub[i +: 4] = nibble_sub(t[i +: 4]);
    for (int unsigned i = 0; i < width; i++) res[(31 * i + 5) % width] = sub[i];
    return res;
  endfunction

  function automatic logic [31:0] feistel_round(input logic [31:0] c, input logic [15:0] k);
    logic [31:0] f;
    f = subst_perm({16'h0, c[15:0]}, {16'h0, k}, 16);
    return {c[15:0], c[31:16] ^ f[15:0]};
  endfunction

  function automatic logic [31:0] keystream_word(input logic [31:0] ctr,
                                                 input logic [31:0] key);
    logic [15:0] k1;
    logic [15:0] k2;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [31:0] s;
    logic [31:0] key32;
    logic [31:0] c;
    k1    = key[31:16];
    k2    = key[15:0];
    hi    = ctr[31:16];
    lo    = ctr[15:0];
    s     = subst_perm({16'h0, hi ^ lo}, {16'h0, rot16(k2, 14)}, 16);
    hi    = hi ^ s[15:0];
    lo    = lo ^ s[15:0];
    key32 = {rot16(k1, 9) ^ k2 ^ KeyMix, rot16(k2, 3)};
    c     = subst_perm({hi, lo}, key32, 32);
    c     = {c[15:0], c[31:16]};
    c     = feistel_round(c, k1);
    return feistel_round(c, k2);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on result %0d: %s got %08h want %08h",
             $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      key_shadow   <= '0;
      iv_shadow    <= '0;
      ctr_shadow   <= '0;
      results_seen = 0;
      cipher_due.delete();
    end else begin
      logic [31:0] ctr_next;
      // results first, so an early result never meets its own prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_due.size() == 0) begin
          report_mismatch("unexpected item, data", m_axis_tdata, 32'h0);
        end else if (m_axis_tdata !== cipher_due[0]) begin
          report_mismatch("cipher_block", m_axis_tdata, cipher_due[0]);
        end
        if (cipher_due.size() != 0) void'(cipher_due.pop_front());
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MASTER_KEY) begin
          key_shadow <= cfg_data;
        end else if (cfg_index == REG_INITIAL_VECTOR) begin
          iv_shadow  <= cfg_data;
          ctr_shadow <= cfg_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ctr_next = ctr_shadow * LcgMul + LcgAdd;
        cipher_due.insert(cipher_due.size(),
                          s_axis_tdata ^ keystream_word(ctr_next, key_shadow));
        ctr_shadow <= s_axis_tlast ? iv_shadow : ctr_next;
      end
    end
    outstanding = cipher_due.size();
  end

endmodule

/* bench/tb_sp_feistel_ctr_cipher32_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sp_feistel_ctr_cipher32_unit
// stimulus and verdict for the feistel ctr cipher unit: directed blocks at the
// field and register extremes, then random messages under several key and
// iv settings, with random idling, a long receiver hold-off and a drain pause
// ----------------------------------------------------------------------------
module tb_sp_feistel_ctr_cipher32_unit;
  import sfc_pkg::*;

  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned PhaseItems     = 48;
  localparam int unsigned LongHoldCycles = 90;
  localparam int unsigned TailCycles     = 10;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [0:0]       cfg_index;
  logic [WordW-1:0] cfg_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [WordW-1:0] s_axis_tdata;   // [31:0] plaintext_block
  logic             s_axis_tlast;   // last_block
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [WordW-1:0] m_axis_tdata;   // [31:0] cipher_block

  int unsigned mismatches;
  int unsigned outstanding;

  // idling switch shared by both sides, and the long hold-off request
  logic idle_on;
  logic long_hold_req;

  sp_feistel_ctr_cipher32_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sfc_stream_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit, far beyond the slowest correct run
  initial begin
    #2ms;
    $display("sp_feistel_ctr_cipher32_unit test failed");
    $finish;
  end

  // register write; cfg_valid drops after the handshake so writes never overlap
  task automatic write_reg(input sfc_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item, maybe after a random gap, and wait for its handshake
  task automatic send_block(input logic [31:0] data, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // stop offering and wait until every predicted block has come back;
  // sampled on the falling edge so the checker's count is settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // register values biased towards the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stall bursts, plus the long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    long_hold_req = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MASTER_KEY;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    idle_on       = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key and iv: after a last block the keystream starts over
    send_block(32'h0000_0000, 1'b0);
    send_block(32'hFFFF_FFFF, 1'b1);
    send_block(32'h0000_0000, 1'b0);
    wait_drained();

    // all-ones key and iv with extreme and alternating data
    write_reg(REG_MASTER_KEY, 32'hFFFF_FFFF);
    write_reg(REG_INITIAL_VECTOR, 32'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 1'b0);
    send_block(32'h0000_0000, 1'b0);
    send_block(32'hAAAA_AAAA, 1'b0);
    send_block(32'h5555_5555, 1'b1);
    send_block(32'h1234_5678, 1'b0);
    wait_drained();

    // new key mid-message: counter carries on
    write_reg(REG_MASTER_KEY, 32'h0000_0000);
    send_block(32'h8000_0001, 1'b0);
    send_block(32'h7FFF_FFFE, 1'b0);
    wait_drained();

    // new iv mid-message: counter reloads at once
    write_reg(REG_INITIAL_VECTOR, 32'h8000_0001);
    send_block(32'hDEAD_BEEF, 1'b0);
    send_block(32'hCAFE_F00D, 1'b1);
    send_block(32'h0F0F_F0F0, 1'b0);

    // back-to-back last blocks, each one reloading the counter
    send_block(32'h0000_0001, 1'b1);
    send_block(32'h8000_0000, 1'b1);
    send_block(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // random messages, a fresh setting for each phase
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MASTER_KEY, 32'h0000_0000);
          write_reg(REG_INITIAL_VECTOR, 32'h0000_0000);
        end
        1: begin
          write_reg(REG_MASTER_KEY, 32'hFFFF_FFFF);
          write_reg(REG_INITIAL_VECTOR, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_MASTER_KEY, pick_word());
          // sometimes the counter just carries on from the last phase
          if ($urandom_range(0, 3) != 0) write_reg(REG_INITIAL_VECTOR, pick_word());
        end
      endcase

      // no idling in the last part of the run
      idle_on = (phase < PhaseCount - 1);
      // one phase with the receiver held off while items keep coming
      if (phase == 2) long_hold_req = 1'b1;

      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // one phase where the sender pauses halfway until all is back
        if (phase == 4 && n == PhaseItems / 2) wait_drained();
        send_block(($urandom_range(0, 9) == 0) ? pick_word() : $urandom,
                   ($urandom_range(0, 7) == 0));
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sp_feistel_ctr_cipher32_unit test passed");
    end else begin
      $display("sp_feistel_ctr_cipher32_unit test failed");
    end
    $finish;
  end

endmodule
